/* hw/rtl/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared widths, request codes and the cell control bundle for the counted
// tag table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  // Payload field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KIND_W  = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned EXTRA_W = 16;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned USED_W  = 7;

  // Request codes (the unused code behaves as a find)
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [EXTRA_W-1:0] extra_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic   capture;  // latch compare result for the incoming request
    kind_t  kind;     // request tags (compare or load)
    level_t level;
    logic   inc;      // add hit: selected cell counts up, saturating
    logic   dec;      // remove hit, nonzero: selected cell counts down
    logic   shift;    // remove hit, zero: cells at or above selection pull down
    logic   load;     // add miss: cell at load index takes the new tags
  } cell_ctrl_t;

endpackage : ctt_pkg

`default_nettype wire

/* hw/rtl/ctt_if.sv */
// ----------------------------------------------------------------------------
// ctt_if
// Valid/ready channel interfaces for requests and results of the counted
// tag table.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_req_if;
  import ctt_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KIND_W-1:0]   kind;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, output mode, output kind, output level, input ready);
  modport sink   (input valid, input mode, input kind, input level, output ready);
endinterface : ctt_req_if

interface ctt_rsp_if;
  import ctt_pkg::*;

  logic                valid;
  logic                ready;
  logic                success;
  logic [POS_W-1:0]    position;
  logic [USED_W-1:0]   entries_used;

  modport source (output valid, output success, output position, output entries_used,
                  input ready);
  modport sink   (input valid, input success, input position, input entries_used,
                  output ready);
endinterface : ctt_rsp_if

`default_nettype wire

/* hw/rtl/counted_tag_table_round_robin_unit.sv */
// ----------------------------------------------------------------------------
// counted_tag_table_round_robin_unit
// Counted (kind, level) tag table with round-robin replacement, built as a
// row of slot cells under a small controller.
// ----------------------------------------------------------------------------
// A request transfer latches every cell's compare against the request; in
// the update state the topmost match is resolved through the cell chain
// and the add, count change or shift-down is committed. The update waits
// while the previous result has not been taken, and no new request is
// taken until the current one is committed. The slots come out of reset
// unwritten; only slots below the used count are ever matched, so no
// clearing pass is needed.
`default_nettype none

module counted_tag_table_round_robin_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire      clk,
  input  wire      rst_n,
  ctt_req_if.sink  in_ch,
  ctt_rsp_if.source out_ch
);
  import ctt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

  state_t             state_r;
  logic [MODE_W-1:0]  mode_r;
  kind_t              kind_r;
  level_t             level_r;
  logic [CNT_W-1:0]   used_r;
  logic [CNT_W-1:0]   used_nxt;
  logic [IDX_W-1:0]   rp_r;
  logic [IDX_W-1:0]   rp_nxt;
  logic               out_valid_r;
  logic               success_r;
  logic [POS_W-1:0]   position_r;
  logic [USED_W-1:0]  used_out_r;

  cell_ctrl_t         ctrl;
  logic [IDX_W-1:0]   load_idx;
  logic               req_xfer;
  logic               go;
  logic               found;
  logic               sel_zero;
  logic [IDX_W-1:0]   hit_pos;
  logic               success_nxt;
  logic [IDX_W-1:0]   pos_nxt;
  logic               is_add;
  logic               is_remove;
  logic               full;

  // Chains between neighboring cells
  logic [TABLE_DEPTH:0]   hit_dn;
  logic [TABLE_DEPTH:0]   zero_dn;
  logic [TABLE_DEPTH:0]   sel_up;
  logic [TABLE_DEPTH-1:0] sel;
  kind_t                  cell_kind  [TABLE_DEPTH];
  level_t                 cell_level [TABLE_DEPTH];
  extra_t                 cell_extra [TABLE_DEPTH];

  assign hit_dn[TABLE_DEPTH]  = 1'b0;
  assign zero_dn[TABLE_DEPTH] = 1'b0;
  assign sel_up[0]            = 1'b0;

  // Handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign req_xfer    = in_ch.valid && in_ch.ready;
  assign go          = (state_r == ST_UPDATE) && (!out_valid_r || out_ch.ready);

  // Request decode
  assign is_add    = (mode_r == MODE_ADD);
  assign is_remove = (mode_r == MODE_REMOVE);
  assign full      = (used_r >= CNT_W'(TABLE_DEPTH));
  assign found     = hit_dn[0];
  assign sel_zero  = zero_dn[0];
  assign load_idx  = full ? rp_r : used_r[IDX_W-1:0];

  // Encode the one-hot selection
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  // Cell control broadcast
  always_comb begin
    ctrl.capture = req_xfer;
    ctrl.kind    = (state_r == ST_IDLE) ? in_ch.kind  : kind_r;
    ctrl.level   = (state_r == ST_IDLE) ? in_ch.level : level_r;
    ctrl.inc     = go && is_add && found;
    ctrl.load    = go && is_add && !found;
    ctrl.dec     = go && is_remove && found && !sel_zero;
    ctrl.shift   = go && is_remove && found && sel_zero;
  end

  // Counter, pointer and result for the request being committed
  always_comb begin
    used_nxt    = used_r;
    rp_nxt      = rp_r;
    success_nxt = found;
    pos_nxt     = found ? hit_pos : '0;
    if (is_add) begin
      success_nxt = 1'b1;
      if (!found) begin
        pos_nxt = load_idx;
        if (!full) begin
          used_nxt = used_r + CNT_W'(1);
        end else if (rp_r == IDX_W'(TABLE_DEPTH - 1)) begin
          rp_nxt = '0;
        end else begin
          rp_nxt = rp_r + IDX_W'(1);
        end
      end
    end else if (is_remove && found && sel_zero) begin
      if (rp_r != '0) begin
        rp_nxt = rp_r - IDX_W'(1);
      end
      if (used_r != '0) begin
        used_nxt = used_r - CNT_W'(1);
      end
    end
  end

  // Controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result stays valid until taken; a commit refills it
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (req_xfer) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (go) begin
            used_r  <= used_nxt;
            rp_r    <= rp_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      mode_r  <= in_ch.mode;
      kind_r  <= in_ch.kind;
      level_r <= in_ch.level;
    end
    if (go) begin
      success_r  <= success_nxt;
      position_r <= POS_W'(pos_nxt);
      used_out_r <= USED_W'(used_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.success      = success_r;
  assign out_ch.position     = position_r;
  assign out_ch.entries_used = used_out_r;

  // Row of slot cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kind_t  a_kind;
    level_t a_level;
    extra_t a_extra;

    // Top slot pulls in cleared tags and keeps its own count
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign a_kind  = '0;
      assign a_level = '0;
      assign a_extra = cell_extra[g];
    end else begin : g_mid
      assign a_kind  = cell_kind[g+1];
      assign a_level = cell_level[g+1];
      assign a_extra = cell_extra[g+1];
    end

    ctt_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .load_idx     (load_idx),
      .used_count   (used_r),
      .above_kind   (a_kind),
      .above_level  (a_level),
      .above_extra  (a_extra),
      .kind         (cell_kind[g]),
      .level        (cell_level[g]),
      .extra        (cell_extra[g]),
      .hit_above_i  (hit_dn[g+1]),
      .zero_above_i (zero_dn[g+1]),
      .hit_above_o  (hit_dn[g]),
      .zero_above_o (zero_dn[g]),
      .sel_below_i  (sel_up[g]),
      .sel_below_o  (sel_up[g+1]),
      .sel_o        (sel[g])
    );
  end

endmodule : counted_tag_table_round_robin_unit

`default_nettype wire

/* hw/rtl/ctt_cell.sv */
// ----------------------------------------------------------------------------
// ctt_cell
// One table slot: holds kind, level and extra count, compares against the
// request, and joins the match chains that run through its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire ctt_pkg::cell_ctrl_t  ctrl,
  input  wire [IDX_W-1:0]           load_idx,
  input  wire [CNT_W-1:0]           used_count,
  // data of the neighbor above, used when shifting down
  input  wire ctt_pkg::kind_t       above_kind,
  input  wire ctt_pkg::level_t      above_level,
  input  wire ctt_pkg::extra_t      above_extra,
  output ctt_pkg::kind_t            kind,
  output ctt_pkg::level_t           level,
  output ctt_pkg::extra_t           extra,
  // downward chain: any hit above, zero flag of the topmost hit
  input  wire                       hit_above_i,
  input  wire                       zero_above_i,
  output logic                      hit_above_o,
  output logic                      zero_above_o,
  // upward chain: selected cell at or below
  input  wire                       sel_below_i,
  output logic                      sel_below_o,
  output logic                      sel_o
);
  import ctt_pkg::*;

  kind_t  kind_r;
  level_t level_r;
  extra_t extra_r;
  logic   hit_r;
  logic   zero_r;
  logic   valid_slot;
  logic   zone;

  // Only slots below the used count take part in matching
  assign valid_slot = (CNT_W'(CELL_IDX) < used_count);

  // Compare capture at request transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      zero_r <= 1'b0;
    end else if (ctrl.capture) begin
      hit_r  <= valid_slot && (kind_r == ctrl.kind) && (level_r == ctrl.level);
      zero_r <= (extra_r == '0);
    end
  end

  // Chain links: topmost hit wins
  always_comb begin
    sel_o        = hit_r && !hit_above_i;
    hit_above_o  = hit_above_i || hit_r;
    zero_above_o = hit_above_i ? zero_above_i : (hit_r && zero_r);
    zone         = sel_below_i || sel_o;
    sel_below_o  = zone;
  end

  // Slot update
  always_ff @(posedge clk) begin
    if (ctrl.load && (load_idx == IDX_W'(CELL_IDX))) begin
      kind_r  <= ctrl.kind;
      level_r <= ctrl.level;
      extra_r <= '0;
    end else if (ctrl.inc && sel_o) begin
      if (extra_r != '1) begin
        extra_r <= extra_r + extra_t'(1);
      end
    end else if (ctrl.dec && sel_o) begin
      extra_r <= extra_r - extra_t'(1);
    end else if (ctrl.shift && zone) begin
      kind_r  <= above_kind;
      level_r <= above_level;
      extra_r <= above_extra;
    end
  end

  assign kind  = kind_r;
  assign level = level_r;
  assign extra = extra_r;

endmodule : ctt_cell

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the counted tag table with round-robin replacement.
// ----------------------------------------------------------------------------
// Requests go in on the request channel and a scoreboard keeps its own copy
// of the table. It works out the success flag, the position and the used
// count for every request transfer, and compares them in order with the
// result transfers. A short directed run covers the empty table, tag
// extremes, all request codes, a run of repeated adds to one entry, a fill
// past the table size with wraparound replacement and the removal of the
// newest entry with a shift-down. A long random run follows over a small
// tag pool, so that hits, shifts and replacements are common. Both sides
// idle at random, and once the result side stalls for a long stretch.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int unsigned TABLE_SLOTS = 64;
  localparam int unsigned POOL_SIZE   = 80;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned REPEAT_ADDS = 60;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Spare request code; the block treats it as a find
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic              success;
    logic [POS_W-1:0]  position;
    logic [USED_W-1:0] entries_used;
  } table_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow table plus the queue of results still owed
  // --------------------------------------------------------------------------
  class tag_table_scoreboard;
    kind_t         slot_kind  [TABLE_SLOTS];
    level_t        slot_level [TABLE_SLOTS];
    extra_t        slot_extra [TABLE_SLOTS];
    int unsigned   used_slots;
    int unsigned   replace_ptr;
    table_result_t pending_results[$];
    int unsigned   errors;

    function new();
      used_slots  = 0;
      replace_ptr = 0;
      errors      = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Apply one request to the shadow table and queue the result it owes
    function void predict_request(logic [MODE_W-1:0] mode, kind_t kind, level_t level);
      int unsigned   slot;
      int unsigned   n;
      bit            hit;
      table_result_t res;
      slot = 0;
      hit  = 1'b0;
      n    = used_slots;
      // topmost match wins
      while (n > 0 && !hit) begin
        n--;
        if (slot_kind[n] == kind && slot_level[n] == level) begin
          hit  = 1'b1;
          slot = n;
        end
      end
      res.success = hit;
      if (mode == MODE_ADD) begin
        res.success = 1'b1;
        if (hit) begin
          if (slot_extra[slot] != '1) slot_extra[slot]++;
        end else begin
          if (used_slots < TABLE_SLOTS) begin
            slot = used_slots;
            used_slots++;
          end else begin
            slot        = replace_ptr;
            replace_ptr = (replace_ptr + 1) % TABLE_SLOTS;
          end
          slot_kind[slot]  = kind;
          slot_level[slot] = level;
          slot_extra[slot] = '0;
        end
      end else if (mode == MODE_REMOVE && hit) begin
        if (slot_extra[slot] != '0) begin
          slot_extra[slot]--;
        end else begin
          // shift down; top slot keeps its count, tags cleared
          for (int unsigned i = slot; i < TABLE_SLOTS - 1; i++) begin
            slot_kind[i]  = slot_kind[i+1];
            slot_level[i] = slot_level[i+1];
            slot_extra[i] = slot_extra[i+1];
          end
          slot_kind[TABLE_SLOTS-1]  = '0;
          slot_level[TABLE_SLOTS-1] = '0;
          if (replace_ptr > 0) replace_ptr--;
          if (used_slots > 0) used_slots--;
        end
      end
      res.position     = POS_W'(slot);
      res.entries_used = USED_W'(used_slots);
      pending_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest expectation
    task check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: success=%0d position=%0d used=%0d",
                         got.success, got.position, got.entries_used));
        return;
      end
      want = pending_results.pop_front();
      if (got.success !== want.success)
        report($sformatf("success %0d, want %0d", got.success, want.success));
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.entries_used !== want.entries_used)
        report($sformatf("entries_used %0d, want %0d", got.entries_used, want.entries_used));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  ctt_req_if req_bus ();
  ctt_rsp_if rsp_bus ();

  counted_tag_table_round_robin_unit #(
    .TABLE_DEPTH (TABLE_SLOTS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus.sink),
    .out_ch (rsp_bus.source)
  );

  tag_table_scoreboard sb;

  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  logic        stall_results;
  logic        random_phase;

  kind_t  pool_kind  [POOL_SIZE];
  level_t pool_level [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: check result transfers, then predict request transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        sb.check_result('{rsp_bus.success, rsp_bus.position, rsp_bus.entries_used});
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
        sb.predict_request(req_bus.mode, req_bus.kind, req_bus.level);
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random ready, forced low during the long stall
  // --------------------------------------------------------------------------
  initial begin
    rsp_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rsp_bus.ready <= !stall_results && ($urandom_range(99) >= rsp_idle_pct);
      @(posedge clk);
    end
  end

  // Long result stall while requests keep coming
  initial begin
    stall_results = 1'b0;
    wait (random_phase === 1'b1);
    repeat (100) @(posedge clk);
    stall_results <= 1'b1;
    repeat (STALL_LEN) @(posedge clk);
    stall_results <= 1'b0;
  end

  // Run limit
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [MODE_W-1:0] mode, input kind_t kind,
                              input level_t level);
    while ($urandom_range(99) < req_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode  <= mode;
    req_bus.kind  <= kind;
    req_bus.level <= level;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
  endtask

  // Random request: mostly pooled tags so hits are common, some fully random
  task automatic random_request(input int unsigned add_pct, input int unsigned remove_pct);
    int unsigned        roll;
    int unsigned        pick;
    logic [MODE_W-1:0]  mode;
    kind_t              kind;
    level_t             level;
    roll = $urandom_range(99);
    if (roll < add_pct)                   mode = MODE_ADD;
    else if (roll < add_pct + remove_pct) mode = MODE_REMOVE;
    else if (roll < 95)                   mode = MODE_FIND;
    else                                  mode = MODE_SPARE;
    if ($urandom_range(99) < 85) begin
      pick  = $urandom_range(POOL_SIZE - 1);
      kind  = pool_kind[pick];
      level = pool_level[pick];
    end else begin
      kind  = kind_t'($urandom);
      level = level_t'($urandom);
    end
    send_request(mode, kind, level);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb            = new();
    random_phase  = 1'b0;
    req_idle_pct  = 27;
    rsp_idle_pct  = 27;
    req_bus.valid = 1'b0;
    req_bus.mode  = MODE_FIND;
    req_bus.kind  = '0;
    req_bus.level = '0;
    rst_n         = 1'b0;
    foreach (pool_kind[i]) begin
      pool_kind[i]  = kind_t'($urandom);
      pool_level[i] = level_t'($urandom);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: find and remove both miss
    send_request(MODE_FIND, 8'h00, 8'h00);
    send_request(MODE_REMOVE, 8'hFF, 8'hFF);
    // Append at the tag extremes
    send_request(MODE_ADD, 8'h00, 8'h00);
    send_request(MODE_ADD, 8'hFF, 8'hFF);
    send_request(MODE_ADD, 8'hAA, 8'h55);
    send_request(MODE_ADD, 8'h55, 8'hAA);
    send_request(MODE_FIND, 8'hFF, 8'hFF);
    send_request(MODE_SPARE, 8'hAA, 8'h55);
    send_request(MODE_SPARE, 8'h12, 8'h34);
    // Count up then down, then shift out the middle entry
    send_request(MODE_ADD, 8'hFF, 8'hFF);
    send_request(MODE_REMOVE, 8'hFF, 8'hFF);
    send_request(MODE_REMOVE, 8'hFF, 8'hFF);
    send_request(MODE_FIND, 8'h55, 8'hAA);
    send_request(MODE_FIND, 8'hFF, 8'hFF);
    // Remove without a match leaves everything alone
    send_request(MODE_REMOVE, 8'h01, 8'h02);
    send_request(MODE_FIND, 8'h00, 8'hFF);

    // Repeated adds to one entry, run without idling on either side
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    for (int unsigned i = 0; i < REPEAT_ADDS; i++)
      send_request(MODE_ADD, 8'hAA, 8'h55);
    send_request(MODE_REMOVE, 8'hAA, 8'h55);
    send_request(MODE_FIND, 8'hAA, 8'h55);
    req_idle_pct = 27;
    rsp_idle_pct = 27;

    // Fill past the table size so replacement wraps, then remove the newest entry
    for (int unsigned i = 0; i < TABLE_SLOTS + 8; i++)
      send_request(MODE_ADD, kind_t'(i + 8'h80), level_t'(8'hC0 - i));
    send_request(MODE_REMOVE, kind_t'(8'h80 + TABLE_SLOTS + 7), level_t'(8'hC0 - TABLE_SLOTS - 7));
    send_request(MODE_REMOVE, 8'h55, 8'hAA);
    send_request(MODE_ADD, 8'h01, 8'h02);
    send_request(MODE_ADD, 8'h03, 8'h04);
    send_request(MODE_ADD, 8'h05, 8'h06);

    // Random run: add-heavy to keep the table full, then balanced
    random_phase <= 1'b1;
    for (int unsigned i = 0; i < 640; i++)
      random_request(65, 20);
    for (int unsigned i = 0; i < 1140; i++)
      random_request(40, 42);
    req_bus.valid <= 1'b0;

    // Drain and let the block settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_top
